// File: design/cpos_pkg.sv
// Shared constants and types for the closest-point-on-segment pipeline.
package cpos_pkg;

	// Fraction bits of the segment parameter produced by the divider.
	localparam int T_FRAC = 32;

	// Result class decided once the dot products are known.
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_START = 2'd0;
	localparam cls_t CLS_END   = 2'd1;
	localparam cls_t CLS_MID   = 2'd2;
	localparam cls_t CLS_DEGEN = 2'd3;

endpackage

// File: design/closest_point_on_segment_core.sv
// Pipelined nearest point on a 3D segment, signed fixed-point coordinates.
//
// Usage: drive the nine coordinates and raise start; a transfer happens at
// each rising edge where start is high and busy is low. busy is always low,
// so a new query may enter in every cycle.
// Each result appears on near_x/y/z and degenerate for exactly one cycle,
// marked by done; the receiver cannot stall it and must take it then.
// A query passes through one stage of differences, one of products, one of sums,
// one of classification, T_FRAC (32) restoring-divider stages that each settle
// one quotient bit, one stage of scaling and one of rounding into the output
// register. Throughput is one query per cycle; the divider is fully
// unrolled into its own pipeline stages.
// A zero-length segment returns the start point with degenerate set.
// Reset (arst_n low) clears every valid bit at once; queries in flight are
// dropped and no done pulse follows.
module closest_point_on_segment_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	input  logic signed [COORD_WIDTH-1:0] query_x,
	input  logic signed [COORD_WIDTH-1:0] query_y,
	input  logic signed [COORD_WIDTH-1:0] query_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] near_x,
	output logic signed [COORD_WIDTH-1:0] near_y,
	output logic signed [COORD_WIDTH-1:0] near_z,
	output logic                          degenerate
);
	import cpos_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;          // differences
	localparam int PW = 2 * DW;         // single products
	localparam int SW = PW + 2;         // sums of three products
	localparam int MW = DW + T_FRAC;    // scaled magnitude
	localparam int RW = MW + 1 - T_FRAC; // rounded magnitude

	typedef logic signed [W-1:0]  crd_t;
	typedef logic signed [DW-1:0] dif_t;

	// Payload carried through the divider stages.
	typedef struct packed {
		logic [SW-1:0]     rem;
		logic [SW-1:0]     den;
		logic [T_FRAC-1:0] q;
		cls_t              cls;
		crd_t [2:0]        s;
		crd_t [2:0]        e;
		dif_t [2:0]        d;
	} div_t;

	logic accept;
	crd_t in_s [3];
	crd_t in_e [3];
	crd_t in_p [3];

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign in_s[0] = start_x;
	assign in_s[1] = start_y;
	assign in_s[2] = start_z;
	assign in_e[0] = end_x;
	assign in_e[1] = end_y;
	assign in_e[2] = end_z;
	assign in_p[0] = query_x;
	assign in_p[1] = query_y;
	assign in_p[2] = query_z;

	// Stage 1: direction and query offset, one bit wider than the inputs.
	logic vld_s1;
	crd_t s_s1 [3];
	crd_t e_s1 [3];
	dif_t d_s1 [3];
	dif_t v_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i] <= in_s[i];
			e_s1[i] <= in_e[i];
			d_s1[i] <= DW'(in_e[i]) - DW'(in_s[i]);
			v_s1[i] <= DW'(in_p[i]) - DW'(in_s[i]);
		end
	end

	// Stage 2: the six products of the two dot products.
	logic vld_s2;
	crd_t s_s2 [3];
	crd_t e_s2 [3];
	dif_t d_s2 [3];
	logic signed [PW-1:0] nd_s2 [3];
	logic signed [PW-1:0] dd_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s2[i]  <= s_s1[i];
			e_s2[i]  <= e_s1[i];
			d_s2[i]  <= d_s1[i];
			nd_s2[i] <= PW'(v_s1[i]) * PW'(d_s1[i]);
			dd_s2[i] <= PW'(d_s1[i]) * PW'(d_s1[i]);
		end
	end

	// Stage 3: exact sums of the products.
	logic vld_s3;
	crd_t s_s3 [3];
	crd_t e_s3 [3];
	dif_t d_s3 [3];
	logic signed [SW-1:0] num_s3;
	logic signed [SW-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		s_s3   <= s_s2;
		e_s3   <= e_s2;
		d_s3   <= d_s2;
		num_s3 <= SW'(nd_s2[0]) + SW'(nd_s2[1]) + SW'(nd_s2[2]);
		den_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
	end

	// Stage 4: classify the parameter and load the divider.
	logic vld_s4;
	div_t dv_s4;
	cls_t cls_c;

	always_comb begin
		if (den_s3 == '0) begin
			cls_c = CLS_DEGEN;
		end else if (num_s3 <= 0) begin
			cls_c = CLS_START;
		end else if (num_s3 >= den_s3) begin
			cls_c = CLS_END;
		end else begin
			cls_c = CLS_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dv_s4.rem <= num_s3;
		dv_s4.den <= den_s3;
		dv_s4.q   <= '0;
		dv_s4.cls <= cls_c;
		for (int i = 0; i < 3; i++) begin
			dv_s4.s[i] <= s_s3[i];
			dv_s4.e[i] <= e_s3[i];
			dv_s4.d[i] <= d_s3[i];
		end
	end

	// Restoring divider: one quotient bit per pipeline stage.
	div_t dv_sd  [T_FRAC+1];
	logic vld_sd [T_FRAC+1];

	assign dv_sd[0]  = dv_s4;
	assign vld_sd[0] = vld_s4;

	for (genvar k = 0; k < T_FRAC; k++) begin : g_div
		logic [SW-1:0] shl;
		logic          ge;
		div_t          nxt;

		always_comb begin
			shl     = {dv_sd[k].rem[SW-2:0], 1'b0};
			ge      = shl >= dv_sd[k].den;
			nxt     = dv_sd[k];
			nxt.rem = ge ? shl - dv_sd[k].den : shl;
			nxt.q   = {dv_sd[k].q[T_FRAC-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_sd[k+1] <= nxt;
		end
	end

	// Scaling stage: magnitude of the direction times the parameter.
	logic vld_sm;
	cls_t cls_sm;
	crd_t s_sm [3];
	crd_t e_sm [3];
	logic neg_sm [3];
	logic [MW-1:0] p_sm [3];
	div_t dq;

	assign dq = dv_sd[T_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else begin
			vld_sm <= vld_sd[T_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		cls_sm <= dq.cls;
		for (int i = 0; i < 3; i++) begin
			s_sm[i]   <= dq.s[i];
			e_sm[i]   <= dq.e[i];
			neg_sm[i] <= dq.d[i][DW-1];
			p_sm[i]   <= MW'(dq.d[i][DW-1] ? -dq.d[i] : dq.d[i]) * MW'(dq.q);
		end
	end

	// Output stage: round half away from zero and select by class.
	logic [MW:0]   rnd  [3];
	logic [RW-1:0] mag  [3];
	crd_t          pick [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (MW+1)'(p_sm[i]) + ((MW+1)'(1) << (T_FRAC - 1));
			mag[i] = rnd[i][MW:T_FRAC];
			case (cls_sm)
				CLS_END: pick[i] = e_sm[i];
				CLS_MID: pick[i] = neg_sm[i] ? s_sm[i] - W'(mag[i]) : s_sm[i] + W'(mag[i]);
				default: pick[i] = s_sm[i];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		near_x     <= pick[0];
		near_y     <= pick[1];
		near_z     <= pick[2];
		degenerate <= (cls_sm == CLS_DEGEN);
	end

endmodule

// File: dv/cpos_checker.sv
// Checker that predicts the nearest point for each query transfer and compares results.
`timescale 1ns / 1ps

module cpos_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	input  logic               done,
	input  logic signed [31:0] near_x,
	input  logic signed [31:0] near_y,
	input  logic signed [31:0] near_z,
	input  logic               degenerate,
	output int                 fail_count,
	output int                 pending_count
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        degen;
	} nearest_t;

	nearest_t nearest_q[$];

	initial begin
		fail_count = 0;
	end

	assign pending_count = nearest_q.size();

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Exact closest point: signed dot products, restoring division, rounding.
	function automatic nearest_t closest_point(input logic signed [31:0] sp[3],
			input logic signed [31:0] ep[3], input logic signed [31:0] qp[3]);
		logic signed [32:0]  dv[3];
		logic signed [32:0]  vv[3];
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic [127:0]        rem;
		logic [31:0]         q;
		logic [32:0]         dmag;
		logic [127:0]        prod;
		logic [63:0]         m;
		logic signed [63:0]  r;
		logic [31:0]         res[3];
		nearest_t            o;
		num = 0;
		den = 0;
		for (int i = 0; i < 3; i++) begin
			dv[i] = 33'(ep[i]) - 33'(sp[i]);
			vv[i] = 33'(qp[i]) - 33'(sp[i]);
			num += 128'(vv[i]) * 128'(dv[i]);
			den += 128'(dv[i]) * 128'(dv[i]);
		end
		o.degen = 1'b0;
		if (den == 0) begin
			o.degen = 1'b1;
			for (int i = 0; i < 3; i++) res[i] = sp[i];
		end else if (num <= 0) begin
			for (int i = 0; i < 3; i++) res[i] = sp[i];
		end else if (num >= den) begin
			for (int i = 0; i < 3; i++) res[i] = ep[i];
		end else begin
			rem = num;
			q = 0;
			for (int i = 0; i < 32; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= den) begin
					rem = rem - den;
					q[0] = 1'b1;
				end
			end
			for (int i = 0; i < 3; i++) begin
				dmag = dv[i] < 0 ? 33'(-dv[i]) : 33'(dv[i]);
				prod = 128'(dmag) * 128'(q) + (128'd1 << 31);
				m = prod[95:32];
				r = dv[i] < 0 ? 64'(sp[i]) - $signed(m) : 64'(sp[i]) + $signed(m);
				res[i] = r[31:0];
			end
		end
		o.x = res[0];
		o.y = res[1];
		o.z = res[2];
		return o;
	endfunction

	// Record each query transfer and check each result against the oldest prediction.
	always @(posedge clk) begin
		logic signed [31:0] sp[3];
		logic signed [31:0] ep[3];
		logic signed [31:0] qp[3];
		nearest_t           want;
		if (arst_n) begin
			if (done) begin
				if (nearest_q.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					fail_count++;
				end else begin
					want = nearest_q.pop_front();
					if (near_x !== want.x) report_mismatch("near_x", near_x, want.x);
					if (near_y !== want.y) report_mismatch("near_y", near_y, want.y);
					if (near_z !== want.z) report_mismatch("near_z", near_z, want.z);
					if (degenerate !== want.degen)
						report_mismatch("degenerate", 32'(degenerate), 32'(want.degen));
				end
			end
			if (start && !busy) begin
				sp = '{start_x, start_y, start_z};
				ep = '{end_x, end_y, end_z};
				qp = '{query_x, query_y, query_z};
				nearest_q.push_back(closest_point(sp, ep, qp));
			end
		end
	end

endmodule

// File: dv/tb_closest_point_on_segment_core.sv
// Testbench top: drives segment queries into the core and gives the verdict.
`timescale 1ns / 1ps

module tb_closest_point_on_segment_core;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] sx, sy, sz, ex, ey, ez, qx, qy, qz;
	logic               done;
	logic signed [31:0] near_x, near_y, near_z;
	logic               degenerate;
	int                 fail_count;
	int                 pending_count;

	localparam int LATENCY = 38;
	localparam int RANDOM_ITEMS = 1650;

	closest_point_on_segment_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(sx), .start_y(sy), .start_z(sz),
		.end_x(ex), .end_y(ey), .end_z(ez),
		.query_x(qx), .query_y(qy), .query_z(qz),
		.done(done), .near_x(near_x), .near_y(near_y), .near_z(near_z),
		.degenerate(degenerate)
	);

	cpos_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(sx), .start_y(sy), .start_z(sz),
		.end_x(ex), .end_y(ey), .end_z(ez),
		.query_x(qx), .query_y(qy), .query_z(qz),
		.done(done), .near_x(near_x), .near_y(near_y), .near_z(near_z),
		.degenerate(degenerate), .fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog for a hung pipeline.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Random coordinate: full range, small range, an extreme, or a medium range in steps of 16.
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0:       return $urandom();
			1:       return 32'($signed($urandom_range(0, 8191)) - 4096);
			2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000) <<< 4;
		endcase
	endfunction

	// One query transfer, after a random gap if allow_gap is set; start stays high between back-to-back items.
	task automatic send_query(input logic [31:0] c[9], input bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{sx, sy, sz} <= {c[0], c[1], c[2]};
		{ex, ey, ez} <= {c[3], c[4], c[5]};
		{qx, qy, qz} <= {c[6], c[7], c[8]};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] c[9];
		int          n;
		bit          gaps;
		start = 1'b0;
		{sx, sy, sz, ex, ey, ez, qx, qy, qz} = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, zero-length segment, parameter below zero, above one, interior.
		send_query('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
		send_query('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0}, 1'b0);
		send_query('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 1'b0);
		send_query('{5, 6, 7, 5, 6, 7, 100, 200, 300}, 1'b0);
		send_query('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0}, 1'b0);
		send_query('{0, 0, 0, 32'h10000, 0, 0, 32'hffff_0000, 5, 5}, 1'b0);
		send_query('{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 5, 5}, 1'b0);
		send_query('{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 9, 9}, 1'b0);
		send_query('{0, 0, 0, 32'h10000, 0, 0, 32'h8000, 0, 0}, 1'b0);
		send_query('{0, 0, 0, 3, 0, 0, 1, 0, 0}, 1'b0);
		send_query('{0, 0, 0, -3, 0, 0, -1, 0, 0}, 1'b0);
		send_query('{0, 0, 0, 1, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 1}, 1'b0);
		send_query('{32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0}, 1'b0);
		send_query('{1, -1, 2, -7, 11, -13, 3, 3, 3}, 1'b0);

		// Pause until the pipeline has drained.
		start <= 1'b0;
		while (pending_count != 0) @(negedge clk);

		// Random queries; about one in twenty has a zero-length segment.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			gaps = ((n / 200) % 3) != 1;
			for (int i = 0; i < 9; i++) c[i] = pick_coord();
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < 3; i++) c[3 + i] = c[i];
			send_query(c, gaps);
			n++;
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				while (pending_count != 0) @(negedge clk);
			end
		end
		start <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
